// File: sv/clt_pkg.sv
package clt_pkg;

    // Fixed field widths of the item and result formats
    localparam int KIND_W = 3;
    localparam int IDX_W  = 11;
    localparam int TERM_W = 32;
    localparam int PAY_W  = 64;

    // Defaults for the top-level parameters
    localparam int DEF_LOG_DEPTH    = 1024;
    localparam int DEF_PAYLOAD_BITS = 64;

    // Input channel layout
    localparam int S_IDX_LSB   = 0;
    localparam int S_TERM_LSB  = S_IDX_LSB + IDX_W;
    localparam int S_ETERM_LSB = S_TERM_LSB + TERM_W;
    localparam int S_EPAY_LSB  = S_ETERM_LSB + TERM_W;
    localparam int S_USED_W    = S_EPAY_LSB + PAY_W;
    localparam int S_TDATA_W   = ((S_USED_W + 7) / 8) * 8;
    localparam int S_KIND_LSB  = 0;
    localparam int S_HAS_BIT   = S_KIND_LSB + KIND_W;
    localparam int S_FIRST_BIT = S_HAS_BIT + 1;
    localparam int S_TUSER_W   = S_FIRST_BIT + 1;

    // Result channel layout
    localparam int M_USED_W  = 4 * IDX_W + 2 * TERM_W + PAY_W;
    localparam int M_TDATA_W = ((M_USED_W + 7) / 8) * 8;
    localparam int M_TUSER_W = 1;

    typedef enum logic [KIND_W-1:0] {
        KIND_APPEND  = 3'd0,
        KIND_BATCH   = 3'd1,
        KIND_READ    = 3'd2,
        KIND_COMMIT  = 3'd3,
        KIND_APPLIED = 3'd4,
        KIND_FIND    = 3'd5,
        KIND_STATUS  = 3'd6
    } kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_PREV,
        S_ENTRY,
        S_MATCH,
        S_READ,
        S_SCAN,
        S_WAIT
    } state_t;

    typedef enum logic [2:0] {
        DP_IDLE,
        DP_DECODE,
        DP_PREV,
        DP_ENTRY,
        DP_MATCH,
        DP_READ,
        DP_SCAN,
        DP_HOLD
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   accept;
        logic   load_out;
    } clt_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  first;
        logic  read_hit;
        logic  empty;
        logic  entry_read;
        logic  scan_done;
    } clt_status_t;

endpackage

// File: sv/clt_ram.sv
module clt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/clt_datapath.sv
module clt_datapath #(
    parameter int LOG_DEPTH    = clt_pkg::DEF_LOG_DEPTH,
    parameter int PAYLOAD_BITS = clt_pkg::DEF_PAYLOAD_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  clt_pkg::clt_cmd_t              cmd,
    output clt_pkg::clt_status_t           status,
    input  logic [clt_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [clt_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic [clt_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [clt_pkg::M_TUSER_W-1:0]  m_tuser
);

    import clt_pkg::*;

    localparam int AW    = $clog2(LOG_DEPTH);
    localparam int LEN_W = $clog2(LOG_DEPTH + 1);
    localparam int NW    = $clog2(LOG_DEPTH + 2);
    localparam int CW    = ((NW > IDX_W) ? NW : IDX_W) + 1;

    // latched item
    kind_t                   kind_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic [TERM_W-1:0]       tval_reg;
    logic [TERM_W-1:0]       eterm_reg;
    logic [PAYLOAD_BITS-1:0] epay_reg;
    logic                    has_entry_reg;
    logic                    first_reg;

    // log state
    logic [LEN_W-1:0]  length_reg,    length_next;
    logic [IDX_W-1:0]  commit_reg,    commit_next;
    logic [IDX_W-1:0]  applied_reg,   applied_next;
    logic              accepting_reg, accepting_next;
    logic [NW-1:0]     next_reg,      next_next;
    logic [TERM_W-1:0] tail_term_reg, tail_term_next;
    logic [AW-1:0]     scan_reg,      scan_next;

    // result of the item in flight
    logic              res_ok_reg,    res_ok_next;
    logic [IDX_W-1:0]  res_found_reg, res_found_next;
    logic [TERM_W-1:0] res_rterm_reg, res_rterm_next;
    logic [PAY_W-1:0]  res_rpay_reg,  res_rpay_next;

    logic [M_TDATA_W-1:0] out_tdata_reg;
    logic                 out_ok_reg;

    // memory ports
    logic                    we;
    logic [AW-1:0]           waddr;
    logic [AW-1:0]           raddr;
    logic [TERM_W-1:0]       rd_term;
    logic [PAYLOAD_BITS-1:0] rd_pay;

    // widened operands for compares
    logic [CW-1:0] idx_c, len_c, pos_c, scan_c, depth_c;
    logic          scan_hit, scan_last, match;

    assign idx_c   = CW'(idx_reg);
    assign len_c   = CW'(length_reg);
    assign pos_c   = CW'(next_reg);
    assign scan_c  = CW'(scan_reg);
    assign depth_c = CW'(LOG_DEPTH);

    assign scan_hit  = (rd_term == tval_reg);
    assign scan_last = ((scan_c + CW'(1)) >= len_c);
    assign match     = (idx_reg == '0) || ((idx_c <= len_c) && (rd_term == tval_reg));

    clt_ram #(
        .WIDTH (TERM_W),
        .DEPTH (LOG_DEPTH)
    ) u_term_ram (
        .aclk    (aclk),
        .wr_en   (we),
        .wr_addr (waddr),
        .wr_data (eterm_reg),
        .rd_addr (raddr),
        .rd_data (rd_term)
    );

    clt_ram #(
        .WIDTH (PAYLOAD_BITS),
        .DEPTH (LOG_DEPTH)
    ) u_pay_ram (
        .aclk    (aclk),
        .wr_en   (we),
        .wr_addr (waddr),
        .wr_data (epay_reg),
        .rd_addr (raddr),
        .rd_data (rd_pay)
    );

    always_comb begin
        length_next    = length_reg;
        commit_next    = commit_reg;
        applied_next   = applied_reg;
        accepting_next = accepting_reg;
        next_next      = next_reg;
        tail_term_next = tail_term_reg;
        scan_next      = scan_reg;
        res_ok_next    = res_ok_reg;
        res_found_next = res_found_reg;
        res_rterm_next = res_rterm_reg;
        res_rpay_next  = res_rpay_reg;
        we             = 1'b0;
        waddr          = AW'(length_reg);
        raddr          = AW'(idx_c - CW'(1));

        case (cmd.op)
            DP_DECODE: begin
                res_ok_next    = 1'b0;
                res_found_next = '0;
                res_rterm_next = '0;
                res_rpay_next  = '0;
                case (kind_reg)
                    KIND_APPEND: begin
                        if (len_c < depth_c) begin
                            we             = 1'b1;
                            length_next    = length_reg + 1'b1;
                            tail_term_next = eterm_reg;
                            res_ok_next    = 1'b1;
                            res_found_next = IDX_W'(len_c + CW'(1));
                        end
                    end
                    KIND_COMMIT: begin
                        if (idx_reg > commit_reg) begin
                            commit_next = idx_reg;
                        end
                        res_ok_next = 1'b1;
                    end
                    KIND_APPLIED: begin
                        applied_next = idx_reg;
                        res_ok_next  = 1'b1;
                    end
                    KIND_FIND: begin
                        raddr     = '0;
                        scan_next = '0;
                    end
                    KIND_STATUS: begin
                        res_ok_next = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            DP_PREV: begin
                accepting_next = match;
                next_next      = match ? NW'(idx_c + CW'(1)) : '0;
            end
            DP_ENTRY: begin
                raddr          = AW'(pos_c - CW'(1));
                res_ok_next    = accepting_reg;
                res_found_next = '0;
                if (accepting_reg && has_entry_reg
                    && !((pos_c != '0) && (pos_c <= len_c))) begin
                    if (len_c < depth_c) begin
                        we             = 1'b1;
                        length_next    = length_reg + 1'b1;
                        tail_term_next = eterm_reg;
                        res_found_next = IDX_W'(len_c + CW'(1));
                        // saturate once past the end of any possible log
                        next_next      = (pos_c > depth_c) ? next_reg : NW'(pos_c + CW'(1));
                    end else begin
                        res_ok_next    = 1'b0;
                        accepting_next = 1'b0;
                        next_next      = '0;
                    end
                end
            end
            DP_MATCH: begin
                if (rd_term != eterm_reg) begin
                    we             = 1'b1;
                    waddr          = AW'(pos_c - CW'(1));
                    length_next    = LEN_W'(pos_c);
                    tail_term_next = eterm_reg;
                end
                res_ok_next    = 1'b1;
                res_found_next = IDX_W'(pos_c);
                next_next      = NW'(pos_c + CW'(1));
            end
            DP_READ: begin
                res_ok_next    = 1'b1;
                res_found_next = idx_reg;
                res_rterm_next = rd_term;
                res_rpay_next  = PAY_W'(rd_pay);
            end
            DP_SCAN: begin
                raddr = AW'(scan_c + CW'(1));
                if (scan_hit) begin
                    res_ok_next    = 1'b1;
                    res_found_next = IDX_W'(scan_c + CW'(1));
                end else if (!scan_last) begin
                    scan_next = AW'(scan_c + CW'(1));
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        status.kind       = kind_reg;
        status.first      = first_reg;
        status.read_hit   = (idx_reg != '0) && (idx_c <= len_c);
        status.empty      = (length_reg == '0);
        status.entry_read = accepting_reg && has_entry_reg
                            && (pos_c != '0) && (pos_c <= len_c);
        status.scan_done  = scan_hit || scan_last;
    end

    // item capture
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            kind_reg      <= kind_t'(s_tuser[S_KIND_LSB +: KIND_W]);
            idx_reg       <= s_tdata[S_IDX_LSB +: IDX_W];
            tval_reg      <= s_tdata[S_TERM_LSB +: TERM_W];
            eterm_reg     <= s_tdata[S_ETERM_LSB +: TERM_W];
            epay_reg      <= s_tdata[S_EPAY_LSB +: PAYLOAD_BITS];
            has_entry_reg <= s_tuser[S_HAS_BIT];
            first_reg     <= s_tuser[S_FIRST_BIT];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            length_reg    <= '0;
            commit_reg    <= '0;
            applied_reg   <= '0;
            accepting_reg <= 1'b0;
            next_reg      <= '0;
            tail_term_reg <= '0;
        end else begin
            length_reg    <= length_next;
            commit_reg    <= commit_next;
            applied_reg   <= applied_next;
            accepting_reg <= accepting_next;
            next_reg      <= next_next;
            tail_term_reg <= tail_term_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_reg      <= scan_next;
        res_ok_reg    <= res_ok_next;
        res_found_reg <= res_found_next;
        res_rterm_reg <= res_rterm_next;
        res_rpay_reg  <= res_rpay_next;
        if (cmd.load_out) begin
            out_ok_reg    <= res_ok_next;
            out_tdata_reg <= M_TDATA_W'({applied_next, commit_next, tail_term_next,
                                         IDX_W'(length_next), res_rpay_next,
                                         res_rterm_next, res_found_next});
        end
    end

    assign m_tdata = out_tdata_reg;
    assign m_tuser = out_ok_reg;

endmodule

// File: sv/clt_ctrl.sv
module clt_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  clt_pkg::clt_status_t status,
    output clt_pkg::clt_cmd_t    cmd
);

    import clt_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;
    logic   finish;
    state_t fin_state;

    assign out_free  = !out_valid_reg || m_tready;
    assign fin_state = out_free ? S_IDLE : S_WAIT;

    // last cycle of an item's work
    always_comb begin
        case (state_reg)
            S_DECODE: begin
                case (status.kind)
                    KIND_BATCH: finish = 1'b0;
                    KIND_READ:  finish = !status.read_hit;
                    KIND_FIND:  finish = status.empty;
                    default:    finish = 1'b1;
                endcase
            end
            S_ENTRY: finish = !status.entry_read;
            S_MATCH: finish = 1'b1;
            S_READ:  finish = 1'b1;
            S_SCAN:  finish = status.scan_done;
            default: finish = 1'b0;
        endcase
    end

    always_comb begin
        case (state_reg)
            S_IDLE: begin
                state_next = s_tvalid ? S_DECODE : S_IDLE;
            end
            S_DECODE: begin
                if (finish) begin
                    state_next = fin_state;
                end else begin
                    case (status.kind)
                        KIND_BATCH: state_next = status.first ? S_PREV : S_ENTRY;
                        KIND_READ:  state_next = S_READ;
                        KIND_FIND:  state_next = S_SCAN;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_PREV:  state_next = S_ENTRY;
            S_ENTRY: state_next = finish ? fin_state : S_MATCH;
            S_MATCH: state_next = fin_state;
            S_READ:  state_next = fin_state;
            S_SCAN:  state_next = finish ? fin_state : S_SCAN;
            S_WAIT:  state_next = out_free ? S_IDLE : S_WAIT;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        case (state_reg)
            S_IDLE:   cmd.op = DP_IDLE;
            S_DECODE: cmd.op = DP_DECODE;
            S_PREV:   cmd.op = DP_PREV;
            S_ENTRY:  cmd.op = DP_ENTRY;
            S_MATCH:  cmd.op = DP_MATCH;
            S_READ:   cmd.op = DP_READ;
            S_SCAN:   cmd.op = DP_SCAN;
            default:  cmd.op = DP_HOLD;
        endcase
        cmd.accept   = (state_reg == S_IDLE) && s_tvalid;
        cmd.load_out = out_free && (finish || (state_reg == S_WAIT));
        s_tready     = (state_reg == S_IDLE);
        m_tvalid     = out_valid_reg;
    end

    assign out_valid_next = cmd.load_out ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: sv/consensus_log_table.sv
// Replicated log table: (term, payload) entries at positions 1..log_length.
// Input channel s_*: one item is one operation, selected by s_tuser kind
// (append, batch entry, read, set commit, set applied, find term, status).
// Result channel m_*: exactly one result item per input item, in order,
// carrying the operation status in m_tuser and a snapshot of the log
// state (length, last term, commit and applied points) in m_tdata.
// Work per item, from accept to result in the output register:
//   append, commit, applied, status: the decode step only
//   read: decode, then one registered read of the entry memories
//   batch entry: decode, previous-term check (first in batch), entry-term
//     compare (entry already in the log); each takes one term-memory read
//   find term: decode, then a scan of up to log_length entries through
//     the single read port, one entry per cycle.
// A new item is taken only when the previous one has finished its work;
// the output register lets it be taken while the previous result waits.
// When m_tready stays low, a finished result parks and the block holds
// until the output register frees up.
// Reset clears the log length, commit, applied and batch state; the entry
// memories are not cleared, positions are only read once written.
module consensus_log_table #(
    parameter int LOG_DEPTH    = clt_pkg::DEF_LOG_DEPTH,
    parameter int PAYLOAD_BITS = clt_pkg::DEF_PAYLOAD_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [10:0] index, [42:11] term, [74:43] entry_term, [138:75] entry_payload
    input  logic [clt_pkg::S_TDATA_W-1:0] s_tdata,
    // [2:0] kind, [3] has_entry, [4] first_in_batch
    input  logic [clt_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [10:0] found_index, [42:11] read_term, [106:43] read_payload,
    // [117:107] log_length, [149:118] last_entry_term, [160:150] commit_point,
    // [171:161] applied_point
    output logic [clt_pkg::M_TDATA_W-1:0] m_tdata,
    // [0] ok
    output logic [clt_pkg::M_TUSER_W-1:0] m_tuser
);

    import clt_pkg::*;

    clt_cmd_t    cmd;
    clt_status_t status;

    // sequence each operation through the memory reads it needs
    clt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // entry memories, log registers and the result register
    clt_datapath #(
        .LOG_DEPTH    (LOG_DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .status  (status),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

endmodule
